FILE: design/macc_pkg.sv
// Shared types, codes and sizes for the multiply-accumulate coprocessor.
package macc_pkg;

    localparam int ACC_W = 40;
    localparam int WORD_W = 32;
    localparam int HALF_W = 16;
    localparam int HIGH_W = ACC_W - WORD_W;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [1:0] CMD_MAC   = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] OP1_VALID = 3'd1;
    localparam logic [2:0] ACC_ZERO  = 3'd0;
    localparam logic [3:0] AOP_ZERO  = 4'd0;

    typedef enum logic [1:0] {
        FORM_FULL = 2'd0,
        FORM_BAD  = 2'd1,
        FORM_DUAL = 2'd2,
        FORM_XY   = 2'd3
    } form_t;

    typedef enum logic [1:0] {
        KIND_REJECT = 2'd0,
        KIND_MAC    = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [2:0]        op1_field;
        logic              two_flag;
        logic              mrc_flag;
        logic [3:0]        opcode_field;
        logic [2:0]        acc_select;
        logic [3:0]        access_op;
        logic [WORD_W-1:0] rs_value;
        logic [WORD_W-1:0] rm_value;
        logic [WORD_W-1:0] write_low;
        logic [WORD_W-1:0] write_high;
    } in_word_t;

    typedef struct packed {
        logic              accepted;
        logic [WORD_W-1:0] read_low;
        logic [HIGH_W-1:0] read_high;
    } out_word_t;

    // Classified operation handed from front to back.
    typedef struct packed {
        kind_t             kind;
        form_t             form;
        logic              x_sel;
        logic              y_sel;
        logic [WORD_W-1:0] rs;
        logic [WORD_W-1:0] rm;
        logic [ACC_W-1:0]  wval;
    } op_t;

endpackage

FILE: design/macc_fifo.sv
// Small register queue with push/full and pop/empty sides.
module macc_fifo #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t wr_data,
    output logic  empty,
    input  logic  pop,
    output item_t rd_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t            mem_reg [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             wr_en;
    logic             rd_en;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_en   = push && !full;
    assign rd_en   = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/macc_front.sv
// Front end: checks the encoding of an incoming word and classifies it.
module macc_front (
    input  macc_pkg::in_word_t in_word,
    output macc_pkg::op_t      op
);
    import macc_pkg::*;

    form_t form;
    logic  acc_ok;
    logic  mac_ok;

    assign form   = form_t'(in_word.opcode_field[3:2]);
    assign acc_ok = (in_word.acc_select == ACC_ZERO) && (in_word.access_op == AOP_ZERO);
    assign mac_ok = (in_word.op1_field == OP1_VALID) && !in_word.two_flag
                 && !in_word.mrc_flag && (in_word.acc_select == ACC_ZERO)
                 && (form != FORM_BAD);

    always_comb
    begin
        op.form  = form;
        op.x_sel = in_word.opcode_field[1];
        op.y_sel = in_word.opcode_field[0];
        op.rs    = in_word.rs_value;
        op.rm    = in_word.rm_value;
        op.wval  = {in_word.write_high[HIGH_W-1:0], in_word.write_low};
        case (in_word.command)
            CMD_MAC:   op.kind = mac_ok ? KIND_MAC : KIND_REJECT;
            CMD_WRITE: op.kind = acc_ok ? KIND_WRITE : KIND_REJECT;
            CMD_READ:  op.kind = acc_ok ? KIND_READ : KIND_REJECT;
            default:   op.kind = KIND_REJECT;
        endcase
    end

endmodule

FILE: design/macc_back.sv
// Back end: multiply stage, then accumulate/read/write stage on the 40-bit accumulator.
module macc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    input  macc_pkg::op_t       op,
    output logic                op_take,
    output logic                res_push,
    input  logic                res_full,
    output macc_pkg::out_word_t res
);
    import macc_pkg::*;

    // Multiply stage registers
    logic                     s1_valid_reg;
    kind_t                    s1_kind_reg;
    logic                     s1_full_reg;
    logic [ACC_W-1:0]         s1_prod_reg;
    logic signed [WORD_W-1:0] s1_pa_reg;
    logic signed [WORD_W-1:0] s1_pb_reg;
    logic [ACC_W-1:0]         s1_wval_reg;

    logic [ACC_W-1:0]         acc_reg, acc_next;

    logic                     s1_take;
    logic signed [2*WORD_W-1:0] full_prod;
    logic signed [HALF_W-1:0] a_m, a_s, b_m, b_s;
    logic signed [WORD_W-1:0] pa, pb;
    logic [ACC_W-1:0]         addend;

    assign s1_take  = !s1_valid_reg || !res_full;
    assign op_take  = op_valid && s1_take;
    assign res_push = s1_valid_reg && !res_full;

    // Pick multiplicand halves: dual uses low*low and high*high, xy uses one pair.
    always_comb
    begin
        full_prod = (2*WORD_W)'($signed(op.rm)) * (2*WORD_W)'($signed(op.rs));
        if (op.form == FORM_DUAL)
        begin
            a_m = op.rm[HALF_W-1:0];
            a_s = op.rs[HALF_W-1:0];
            b_m = op.rm[WORD_W-1:HALF_W];
            b_s = op.rs[WORD_W-1:HALF_W];
        end
        else
        begin
            a_m = op.x_sel ? op.rm[WORD_W-1:HALF_W] : op.rm[HALF_W-1:0];
            a_s = op.y_sel ? op.rs[WORD_W-1:HALF_W] : op.rs[HALF_W-1:0];
            b_m = '0;
            b_s = '0;
        end
        pa = WORD_W'(a_m) * WORD_W'(a_s);
        pb = WORD_W'(b_m) * WORD_W'(b_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            s1_kind_reg <= op.kind;
            s1_full_reg <= (op.form == FORM_FULL);
            s1_prod_reg <= full_prod[ACC_W-1:0];
            s1_pa_reg   <= pa;
            s1_pb_reg   <= pb;
            s1_wval_reg <= op.wval;
        end
    end

    always_comb
    begin
        addend = s1_full_reg ? s1_prod_reg
               : {{HIGH_W{s1_pa_reg[WORD_W-1]}}, s1_pa_reg}
               + {{HIGH_W{s1_pb_reg[WORD_W-1]}}, s1_pb_reg};
        acc_next = acc_reg;
        case (s1_kind_reg)
            KIND_MAC:   acc_next = acc_reg + addend;
            KIND_WRITE: acc_next = s1_wval_reg;
            default:    acc_next = acc_reg;
        endcase
        res.accepted  = (s1_kind_reg != KIND_REJECT);
        res.read_low  = (s1_kind_reg == KIND_READ) ? acc_reg[WORD_W-1:0] : '0;
        res.read_high = (s1_kind_reg == KIND_READ) ? acc_reg[ACC_W-1:WORD_W] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (res_push)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

FILE: design/mac_accumulator_coprocessor_top.sv
// Top level of the multiply-accumulate coprocessor.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------
//   command  | in        | push / full          | in_word (in_word_t)
//   result   | out       | empty / pop          | out_word (out_word_t)
//
// One word per cycle in steady state while results are popped; each word
// gives exactly one result word. An accepted word is decoded into the middle
// queue, then registered in the multiply stage, then passes the accumulate
// stage into the result queue, from which it shows on out_word.
// The 40-bit accumulator add in the last stage closes the loop on each result push.
// Reset clears the queues and the accumulator; a stalled pop backs the pipe
// up into the middle queue, and full rises only once that queue is filled.
module mac_accumulator_coprocessor_top #(
    parameter int MID_DEPTH = macc_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = macc_pkg::OUT_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  macc_pkg::in_word_t  in_word,
    output logic                empty,
    input  logic                pop,
    output macc_pkg::out_word_t out_word
);
    import macc_pkg::*;

    op_t       front_op;
    op_t       mid_op;
    logic      mid_empty;
    logic      mid_take;
    logic      res_push;
    logic      res_full;
    out_word_t res;

    macc_front u_front (
        .in_word (in_word),
        .op      (front_op)
    );

    macc_fifo #(
        .item_t (op_t),
        .DEPTH  (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .wr_data (front_op),
        .empty   (mid_empty),
        .pop     (mid_take),
        .rd_data (mid_op)
    );

    macc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (!mid_empty),
        .op       (mid_op),
        .op_take  (mid_take),
        .res_push (res_push),
        .res_full (res_full),
        .res      (res)
    );

    macc_fifo #(
        .item_t (out_word_t),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .full    (res_full),
        .wr_data (res),
        .empty   (empty),
        .pop     (pop),
        .rd_data (out_word)
    );

endmodule

FILE: design/macc_checker.sv
// Port-level checks on the coprocessor top level, bound to it.
module macc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input macc_pkg::out_word_t out_word
);
    import macc_pkg::*;

    // Queues come out of reset empty and open.
    a_reset_state: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not cleared by reset");

    // A rejected word never carries read data.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_word.accepted) |-> (out_word.read_low == '0 && out_word.read_high == '0))
        else $error("rejected word carries read data");

    // The input side backs up only behind a waiting result.
    a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full with no result waiting");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without pop");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(out_word))
        else $error("stalled result word changed");

endmodule

bind mac_accumulator_coprocessor_top macc_checker u_macc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
);

FILE: tb/tb_mac_accumulator_coprocessor_top.sv
// Self-checking testbench for the multiply-accumulate coprocessor top level.
`timescale 1ns / 100ps

module tb_mac_accumulator_coprocessor_top;

    import macc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES = 200000;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        in_word_t word;
        bit       drain;
    } stim_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b1;
    logic      push = 1'b0;
    logic      full;
    in_word_t  in_word = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_word_t out_word;

    stim_t     stimulus[$];
    out_word_t due_words[$];
    logic [ACC_W-1:0] acc_model = '0;

    int sent_count;
    int got_count;
    int mismatches = 0;
    int rejects = 0;
    int reads_seen = 0;
    int holds_done = 0;
    int drains_done = 0;
    int cycles = 0;
    int gap_left = 0;
    int idle_left = 0;
    bit offer;
    stim_t     next_stim;
    out_word_t want;

    mac_accumulator_coprocessor_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_word  (in_word),
        .empty    (empty),
        .pop      (pop),
        .out_word (out_word)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Accumulator model: update state for one accepted word and return its result.
    function automatic out_word_t compute_response(input in_word_t w);
        out_word_t r;
        form_t f;
        logic signed [WORD_W-1:0] m32, s32;
        logic signed [HALF_W-1:0] m_lo, m_hi, s_lo, s_hi, m_pick, s_pick;
        logic signed [63:0] prod;
        r = '0;
        f = form_t'(w.opcode_field[3:2]);
        m32 = w.rm_value;
        s32 = w.rs_value;
        m_lo = w.rm_value[HALF_W-1:0];
        m_hi = w.rm_value[WORD_W-1:HALF_W];
        s_lo = w.rs_value[HALF_W-1:0];
        s_hi = w.rs_value[WORD_W-1:HALF_W];
        m_pick = w.opcode_field[1] ? m_hi : m_lo;
        s_pick = w.opcode_field[0] ? s_hi : s_lo;
        case (w.command)
            CMD_MAC:
                if (w.op1_field == OP1_VALID && !w.two_flag && !w.mrc_flag
                    && w.acc_select == ACC_ZERO && f != FORM_BAD)
                begin
                    case (f)
                        FORM_FULL: prod = 64'(m32) * 64'(s32);
                        FORM_DUAL: prod = 64'(m_lo) * 64'(s_lo) + 64'(m_hi) * 64'(s_hi);
                        default:   prod = 64'(m_pick) * 64'(s_pick);
                    endcase
                    acc_model = acc_model + prod[ACC_W-1:0];
                    r.accepted = 1'b1;
                end
            CMD_WRITE, CMD_READ:
                if (w.acc_select == ACC_ZERO && w.access_op == AOP_ZERO)
                begin
                    if (w.command == CMD_READ)
                    begin
                        r.read_low = acc_model[WORD_W-1:0];
                        r.read_high = acc_model[ACC_W-1:WORD_W];
                    end
                    else
                        acc_model = {w.write_high[HIGH_W-1:0], w.write_low};
                    r.accepted = 1'b1;
                end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_8000;
            4: return 32'h7FFF_7FFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_word_t noise_word();
        in_word_t w;
        w.command = 2'($urandom_range(0, 3));
        w.op1_field = 3'($urandom_range(0, 7));
        w.two_flag = 1'($urandom_range(0, 1));
        w.mrc_flag = 1'($urandom_range(0, 1));
        w.opcode_field = 4'($urandom_range(0, 15));
        w.acc_select = 3'($urandom_range(0, 7));
        w.access_op = 4'($urandom_range(0, 15));
        w.rs_value = pick_operand();
        w.rm_value = pick_operand();
        w.write_low = pick_operand();
        w.write_high = $urandom;
        return w;
    endfunction

    function automatic in_word_t mac_word(input form_t f, input logic x, input logic y,
                                          input logic [WORD_W-1:0] rm,
                                          input logic [WORD_W-1:0] rs);
        in_word_t w;
        w = noise_word();
        w.command = CMD_MAC;
        w.op1_field = OP1_VALID;
        w.two_flag = 1'b0;
        w.mrc_flag = 1'b0;
        w.acc_select = ACC_ZERO;
        w.opcode_field = {f, x, y};
        w.rm_value = rm;
        w.rs_value = rs;
        return w;
    endfunction

    function automatic in_word_t access_word(input logic [1:0] cmd,
                                             input logic [WORD_W-1:0] lo,
                                             input logic [WORD_W-1:0] hi);
        in_word_t w;
        w = noise_word();
        w.command = cmd;
        w.acc_select = ACC_ZERO;
        w.access_op = AOP_ZERO;
        w.write_low = lo;
        w.write_high = hi;
        return w;
    endfunction

    function automatic in_word_t random_word();
        form_t forms[3];
        int pick;
        forms[0] = FORM_FULL;
        forms[1] = FORM_DUAL;
        forms[2] = FORM_XY;
        pick = $urandom_range(0, 99);
        if (pick < 68)
            return mac_word(forms[$urandom_range(0, 2)], 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), pick_operand(), pick_operand());
        else if (pick < 78)
            return access_word(CMD_WRITE, pick_operand(), $urandom);
        else if (pick < 92)
            return access_word(CMD_READ, $urandom, $urandom);
        else
            return noise_word();
    endfunction

    task automatic queue_word(input in_word_t w, input bit drain);
        stim_t s;
        s.word = w;
        s.drain = drain;
        stimulus.push_back(s);
    endtask

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got_v,
                                 input logic [WORD_W-1:0] want_v);
        if (mismatches < MAX_PRINTS)
            $display("mismatch on %s, result word %0d: got %h, expected %h",
                     what, got_count, got_v, want_v);
        mismatches++;
    endtask

    // Sender: hold the word while full, then take the next one after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            in_word <= '0;
            sent_count <= 0;
            gap_left = 0;
        end
        else
        begin
            offer = push && full;
            if (push && !full)
            begin
                due_words.push_back(compute_response(in_word));
                sent_count <= sent_count + 1;
                gap_left = ((sent_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 6);
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (stimulus.size() != 0 && (!stimulus[0].drain
                         || (!push && sent_count == got_count)))
                begin
                    next_stim = stimulus.pop_front();
                    if (next_stim.drain)
                        drains_done++;
                    in_word <= next_stim.word;
                    offer = 1'b1;
                end
            end
            push <= offer;
        end
    end

    // Receiver: check each popped word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            got_count <= 0;
            idle_left = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (due_words.size() == 0)
                    flag_mismatch("unexpected word", out_word.read_low, '0);
                else
                begin
                    want = due_words.pop_front();
                    if (!want.accepted)
                        rejects++;
                    if (want.read_low != 0 || want.read_high != 0)
                        reads_seen++;
                    if (out_word.accepted !== want.accepted)
                        flag_mismatch("accepted", WORD_W'(out_word.accepted),
                                      WORD_W'(want.accepted));
                    if (out_word.read_low !== want.read_low)
                        flag_mismatch("read_low", out_word.read_low, want.read_low);
                    if (out_word.read_high !== want.read_high)
                        flag_mismatch("read_high", WORD_W'(out_word.read_high),
                                      WORD_W'(want.read_high));
                end
                got_count <= got_count + 1;
                idle_left = ((got_count / 50) % 3 == 1) ? 0 : $urandom_range(0, 6);
                // Back the pipe up so full has to rise.
                if (got_count + 1 == 300 || got_count + 1 == 620)
                begin
                    idle_left = HOLD_CYCLES;
                    holds_done++;
                end
            end
            if (idle_left > 0)
            begin
                idle_left--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycles,
                     due_words.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        // Directed words: extremes, each form, every reject path.
        queue_word(access_word(CMD_READ, '0, '0), 1'b0);
        queue_word(access_word(CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
        queue_word(access_word(CMD_READ, '0, '0), 1'b0);
        queue_word(mac_word(FORM_FULL, 1'b0, 1'b0, 32'h1, 32'h1), 1'b0);
        queue_word(access_word(CMD_READ, '0, '0), 1'b0);
        queue_word(mac_word(FORM_FULL, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000), 1'b0);
        queue_word(mac_word(FORM_FULL, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0);
        queue_word(access_word(CMD_READ, '0, '0), 1'b0);
        queue_word(access_word(CMD_WRITE, '0, 32'hFFFF_FF00), 1'b0);
        queue_word(mac_word(FORM_DUAL, 1'b0, 1'b0, 32'h8000_8000, 32'h8000_8000), 1'b0);
        queue_word(mac_word(FORM_XY, 1'b0, 1'b0, 32'h0001_FFFF, 32'h0002_0003), 1'b0);
        queue_word(mac_word(FORM_XY, 1'b1, 1'b0, 32'h8000_0005, 32'h7FFF_FFFF), 1'b0);
        queue_word(mac_word(FORM_XY, 1'b0, 1'b1, 32'hFFFF_8000, 32'h8000_0001), 1'b0);
        queue_word(mac_word(FORM_XY, 1'b1, 1'b1, 32'h7FFF_0000, 32'h7FFF_FFFF), 1'b0);
        queue_word(access_word(CMD_READ, '0, '0), 1'b0);
        queue_word(mac_word(FORM_BAD, 1'b1, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0), 1'b0);
        next_stim.word = mac_word(FORM_FULL, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h3);
        next_stim.word.op1_field = 3'd0;
        queue_word(next_stim.word, 1'b0);
        next_stim.word.op1_field = OP1_VALID;
        next_stim.word.two_flag = 1'b1;
        queue_word(next_stim.word, 1'b0);
        next_stim.word.two_flag = 1'b0;
        next_stim.word.mrc_flag = 1'b1;
        queue_word(next_stim.word, 1'b0);
        next_stim.word.mrc_flag = 1'b0;
        next_stim.word.acc_select = 3'd7;
        queue_word(next_stim.word, 1'b0);
        next_stim.word = access_word(CMD_WRITE, 32'hDEAD_BEEF, 32'h55);
        next_stim.word.acc_select = 3'd2;
        queue_word(next_stim.word, 1'b0);
        next_stim.word = access_word(CMD_READ, '0, '0);
        next_stim.word.access_op = 4'hF;
        queue_word(next_stim.word, 1'b0);
        next_stim.word = access_word(CMD_WRITE, 32'hCAFE_F00D, 32'h7F);
        next_stim.word.command = 2'd3;
        queue_word(next_stim.word, 1'b0);
        queue_word(access_word(CMD_READ, '0, '0), 1'b0);
        queue_word(access_word(CMD_WRITE, 32'h1234_5678, 32'hABCD_EF80), 1'b0);
        queue_word(access_word(CMD_READ, '0, '0), 1'b0);

        for (int i = 0; i < RANDOM_WORDS; i++)
            queue_word(random_word(), i == 250 || i == 550);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Sample between edges so the sender's updates have settled.
        while (stimulus.size() != 0 || push || due_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d words checked: %0d rejected encodings, %0d nonzero reads",
                 got_count, rejects, reads_seen);
        $display("%0d receiver hold-offs with the input backed up, %0d sender drains",
                 holds_done, drains_done);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/macc_pkg.sv
design/macc_fifo.sv
design/macc_front.sv
design/macc_back.sv
design/mac_accumulator_coprocessor_top.sv
design/macc_checker.sv
tb/tb_mac_accumulator_coprocessor_top.sv
